// File: rtl/bevd_pkg.sv
package bevd_pkg;

  localparam int SMP_W     = 16;
  localparam int CNT_W     = 18;
  localparam int SQ_W      = 31;
  localparam int MS_W      = 31;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;

  localparam logic [CNT_W-1:0] RUN_MAX = '1;

  typedef enum logic [1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_STOP    = 2'd1,
    MODE_CANCEL  = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_RECORDING = 2'd0,
    ST_VOICED    = 2'd1,
    ST_NO_VOICE  = 2'd2,
    ST_CANCELLED = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SAMPLES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_GUARD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SILENCE   = 3'd4;

  // one classified item on its way from front to back
  typedef struct packed {
    mode_t                   mode;
    logic signed [SMP_W-1:0] sample;
    logic [SQ_W-1:0]         sq;
  } item_t;

  // settings seen by the back end, limit already clamped
  typedef struct packed {
    logic [CNT_W-1:0] lim;
    logic [MS_W-1:0]  smsq;
    logic [CNT_W-1:0] guard;
    logic [CNT_W-1:0] tail;
  } cfg_t;

endpackage

// File: rtl/bevd_front.sv
module bevd_front import bevd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_mode,
  input  logic signed [SMP_W-1:0] in_sample_in,
  input  logic                    q_full,
  output logic                    push,
  output item_t                   push_item
);

  logic          f_valid_r, f_valid_nxt;
  item_t         f_item_r;
  logic [16:0]   mag;
  logic [33:0]   prod;
  logic          accept;

  // magnitude 0..32768, then its square
  always_comb begin
    if (in_sample_in[SMP_W-1]) begin
      mag = 17'd0 - {1'b1, in_sample_in};
    end else begin
      mag = {1'b0, in_sample_in};
    end
    prod = mag * mag;
  end

  assign in_ready  = !f_valid_r || !q_full;
  assign accept    = in_valid && in_ready;
  assign push      = f_valid_r && !q_full;
  assign push_item = f_item_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r.mode   <= mode_t'(in_mode);
      f_item_r.sample <= in_sample_in;
      f_item_r.sq     <= prod[SQ_W-1:0];
    end
  end

endmodule

// File: rtl/bevd_queue.sv
module bevd_queue import bevd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  item_t           entry_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == CW'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/bevd_back.sv
module bevd_back import bevd_pkg::*; #(
  parameter int MAX_BLOCK = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  item_t                                q_item,
  output logic                                 pop,
  input  cfg_t                                 cfg,
  input  logic [$clog2(MAX_BLOCK+1)-1:0]       blk,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_sample_valid,
  output logic signed [SMP_W-1:0]              out_sample_out,
  output logic [CNT_W-1:0]                     out_sample_count,
  output logic                                 out_finished,
  output logic [1:0]                           out_status
);

  localparam int BW = $clog2(MAX_BLOCK + 1);
  // block sum of squares and threshold times fill share one width
  localparam int AW = BW + MS_W;

  logic [AW-1:0]           e_r, e_nxt, e_sum, need;
  logic [BW-1:0]           fill_r, fill_nxt, fill_inc;
  logic [CNT_W-1:0]        total_r, total_nxt, total_inc;
  logic [CNT_W-1:0]        run_r, run_nxt, run_sat;
  logic [CNT_W:0]          run_sum;
  logic                    heard_r, heard_nxt;
  logic                    ended_r, ended_nxt;

  logic                    ovalid_r, ovalid_nxt;
  logic                    o_sv_r, o_sv_nxt;
  logic signed [SMP_W-1:0] o_smp_r, o_smp_nxt;
  logic [CNT_W-1:0]        o_cnt_r, o_cnt_nxt;
  logic                    o_fin_r, o_fin_nxt;
  status_t                 o_st_r, o_st_nxt;

  logic                    produces, load;
  logic                    closes, voiced, fin;

  assign produces = (q_item.mode != MODE_RESTART) && !ended_r;
  assign pop      = q_valid && (!ovalid_r || out_ready || !produces);

  always_comb begin
    e_sum     = e_r + {{(AW-SQ_W){1'b0}}, q_item.sq};
    fill_inc  = fill_r + 1'b1;
    total_inc = total_r + 1'b1;
    need      = {{BW{1'b0}}, cfg.smsq} * {{MS_W{1'b0}}, fill_inc};
    run_sum   = {1'b0, run_r} + {{(CNT_W+1-BW){1'b0}}, fill_inc};
    run_sat   = run_sum[CNT_W] ? RUN_MAX : run_sum[CNT_W-1:0];
    closes    = (fill_inc >= blk) || (total_inc >= cfg.lim);
    voiced    = (e_sum >= need);
  end

  always_comb begin
    e_nxt     = e_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    run_nxt   = run_r;
    heard_nxt = heard_r;
    ended_nxt = ended_r;
    load      = 1'b0;
    fin       = 1'b0;
    o_sv_nxt  = 1'b0;
    o_smp_nxt = '0;
    o_cnt_nxt = total_r;
    o_fin_nxt = 1'b0;
    o_st_nxt  = ST_RECORDING;
    if (pop) begin
      case (q_item.mode)
        MODE_RESTART: begin
          e_nxt     = '0;
          fill_nxt  = '0;
          total_nxt = '0;
          run_nxt   = '0;
          heard_nxt = 1'b0;
          ended_nxt = 1'b0;
        end
        MODE_STOP: begin
          if (!ended_r) begin
            ended_nxt = 1'b1;
            load      = 1'b1;
            o_fin_nxt = 1'b1;
            o_st_nxt  = heard_r ? ST_VOICED : ST_NO_VOICE;
          end
        end
        MODE_CANCEL: begin
          if (!ended_r) begin
            ended_nxt = 1'b1;
            load      = 1'b1;
            o_fin_nxt = 1'b1;
            o_st_nxt  = ST_CANCELLED;
          end
        end
        MODE_SAMPLE: begin
          if (!ended_r) begin
            load = 1'b1;
            if (total_r >= cfg.lim) begin
              // limit already reached: drop the sample and finish
              ended_nxt = 1'b1;
              o_fin_nxt = 1'b1;
              o_st_nxt  = heard_r ? ST_VOICED : ST_NO_VOICE;
            end else begin
              total_nxt = total_inc;
              if (closes) begin
                e_nxt    = '0;
                fill_nxt = '0;
                if (voiced) begin
                  heard_nxt = 1'b1;
                  run_nxt   = '0;
                end else if (total_inc >= cfg.guard) begin
                  run_nxt = run_sat;
                  if (run_sat >= cfg.tail) begin
                    fin = 1'b1;
                  end
                end
                if (total_inc >= cfg.lim) begin
                  fin = 1'b1;
                end
              end else begin
                e_nxt    = e_sum;
                fill_nxt = fill_inc;
              end
              ended_nxt = fin;
              o_sv_nxt  = 1'b1;
              o_smp_nxt = q_item.sample;
              o_cnt_nxt = total_inc;
              o_fin_nxt = fin;
              o_st_nxt  = fin ? (heard_nxt ? ST_VOICED : ST_NO_VOICE) : ST_RECORDING;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (load) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r      <= '0;
      fill_r   <= '0;
      total_r  <= '0;
      run_r    <= '0;
      heard_r  <= 1'b0;
      ended_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      e_r      <= e_nxt;
      fill_r   <= fill_nxt;
      total_r  <= total_nxt;
      run_r    <= run_nxt;
      heard_r  <= heard_nxt;
      ended_r  <= ended_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_sv_r  <= o_sv_nxt;
      o_smp_r <= o_smp_nxt;
      o_cnt_r <= o_cnt_nxt;
      o_fin_r <= o_fin_nxt;
      o_st_r  <= o_st_nxt;
    end
  end

  assign out_valid        = ovalid_r;
  assign out_sample_valid = o_sv_r;
  assign out_sample_out   = o_smp_r;
  assign out_sample_count = o_cnt_r;
  assign out_finished     = o_fin_r;
  assign out_status       = o_st_r;

endmodule

// File: rtl/block_energy_voice_endpoint_detector.sv
// Path: an accepted input is held in the front register, then in a queue entry, then in the
// output register; back-pressure from out_ready can hold it at each of these.
// Throughput: one item per cycle while out_ready is high; the back end's single energy
// accumulate-and-compare stage takes a sample every cycle. Stop, cancel and restart take the same slot.
// Reset: rst_n is synchronous, active low; clears all detector state and queue, and loads
// the register defaults. No clearing pass is needed.
module block_energy_voice_endpoint_detector import bevd_pkg::*; #(
  parameter int MAX_BLOCK  = 512,
  parameter int MAX_RECORD = 160000
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_mode,
  input  logic signed [SMP_W-1:0] in_sample_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_sample_valid,
  output logic signed [SMP_W-1:0] out_sample_out,
  output logic [CNT_W-1:0]        out_sample_count,
  output logic                    out_finished,
  output logic [1:0]              out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [MS_W-1:0]         cfg_data
);

  localparam int BW = $clog2(MAX_BLOCK + 1);

  function automatic logic [CNT_W-1:0] clamp_lim(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_RECORD) begin
      r = CNT_W'(MAX_RECORD);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [BW-1:0] clamp_blk(input logic [9:0] v);
    logic [BW-1:0] r;
    if (v == '0) begin
      r = BW'(1);
    end else if (32'(v) > MAX_BLOCK) begin
      r = BW'(MAX_BLOCK);
    end else begin
      r = BW'(v);
    end
    return r;
  endfunction

  cfg_t          cfg_r;
  logic [BW-1:0] blk_r;
  logic          cfg_wr;

  logic          q_full, push, q_valid, pop;
  item_t         push_item, q_item;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lim   <= clamp_lim(CNT_W'(48000));
      blk_r       <= clamp_blk(10'd512);
      cfg_r.smsq  <= MS_W'(339553);
      cfg_r.guard <= CNT_W'(9600);
      cfg_r.tail  <= CNT_W'(12800);
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_MAX_SAMPLES:   cfg_r.lim   <= clamp_lim(cfg_data[CNT_W-1:0]);
        CFG_BLOCK_SAMPLES: blk_r       <= clamp_blk(cfg_data[9:0]);
        CFG_SILENCE_MS:    cfg_r.smsq  <= cfg_data;
        CFG_START_GUARD:   cfg_r.guard <= cfg_data[CNT_W-1:0];
        CFG_TAIL_SILENCE:  cfg_r.tail  <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bevd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_sample_in (in_sample_in),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  bevd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  bevd_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .pop              (pop),
    .cfg              (cfg_r),
    .blk              (blk_r),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_sample_valid (out_sample_valid),
    .out_sample_out   (out_sample_out),
    .out_sample_count (out_sample_count),
    .out_finished     (out_finished),
    .out_status       (out_status)
  );

endmodule
